[rtl/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 32;
	localparam int unsigned VAL_W = 32;

	localparam logic [7:0] CH_ADD = 8'h2B;
	localparam logic [7:0] CH_SUB = 8'h2D;
	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_DIV = 8'h2F;
	localparam logic [7:0] CH_POW = 8'h5E;
	localparam logic [7:0] CH_D0 = 8'h30;
	localparam logic [7:0] CH_D9 = 8'h39;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	typedef enum logic [2:0] {
		K_NOP = 3'd0,
		K_PUSH = 3'd1,
		K_ADD = 3'd2,
		K_SUB = 3'd3,
		K_MUL = 3'd4,
		K_DIV = 3'd5,
		K_POW = 3'd6
	} kind_t;

	// decoded command passed from the front end to the execution unit
	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       last;
	} cmd_t;

	localparam int unsigned CMD_W = $bits(cmd_t);

endpackage

[rtl/pfe_ram.sv]
// ----------------------------------------------------------------------------
// pfe_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pfe_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/pfe_front.sv]
// ----------------------------------------------------------------------------
// pfe_front
// Character decoder and a two-entry command queue.
// ----------------------------------------------------------------------------
module pfe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    ch,
	input  logic          last,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output pfe_pkg::cmd_t cmd
);

	pfe_pkg::cmd_t cmd_dec;
	pfe_pkg::cmd_t buf_q [2];
	logic          rd_q;
	logic          wr_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	always_comb begin
		cmd_dec.kind = pfe_pkg::K_NOP;
		cmd_dec.digit = ch[3:0];
		cmd_dec.last = last;
		if (ch >= pfe_pkg::CH_D0 && ch <= pfe_pkg::CH_D9) begin
			cmd_dec.kind = pfe_pkg::K_PUSH;
		end else if (ch == pfe_pkg::CH_ADD) begin
			cmd_dec.kind = pfe_pkg::K_ADD;
		end else if (ch == pfe_pkg::CH_SUB) begin
			cmd_dec.kind = pfe_pkg::K_SUB;
		end else if (ch == pfe_pkg::CH_MUL) begin
			cmd_dec.kind = pfe_pkg::K_MUL;
		end else if (ch == pfe_pkg::CH_DIV) begin
			cmd_dec.kind = pfe_pkg::K_DIV;
		end else if (ch == pfe_pkg::CH_POW) begin
			cmd_dec.kind = pfe_pkg::K_POW;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = buf_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cmd_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

[rtl/pfe_divpow.sv]
// ----------------------------------------------------------------------------
// pfe_divpow
// Iterative unit: restoring signed divide (one bit per cycle) and
// square-and-multiply power (a multiply step and a square step per exponent bit).
// ----------------------------------------------------------------------------
module pfe_divpow (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_pow,
	input  logic [31:0] b,
	input  logic [31:0] a,
	output logic        done,
	output logic [31:0] res
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_PMUL = 4'b0100,
		S_PSQ  = 4'b1000
	} st_t;

	st_t         st_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [31:0] acc_q;
	logic [31:0] sq_q;
	logic [31:0] exp_q;
	logic [32:0] trial;
	logic [31:0] rsh;
	logic [31:0] b_mag;
	logic [31:0] a_mag;

	assign b_mag = b[31] ? (32'd0 - b) : b;
	assign a_mag = a[31] ? (32'd0 - a) : a;
	assign rsh = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, rsh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			res <= 32'd0;
			rem_q <= 32'd0;
			quo_q <= 32'd0;
			den_q <= 32'd0;
			cnt_q <= 6'd0;
			neg_q <= 1'b0;
			acc_q <= 32'd0;
			sq_q <= 32'd0;
			exp_q <= 32'd0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						if (is_pow) begin
							if (a[31]) begin
								done <= 1'b1;
								if (b == 32'd1) res <= 32'd1;
								else if (b == 32'hFFFF_FFFF)
									res <= a[0] ? 32'hFFFF_FFFF : 32'd1;
								else res <= 32'd0;
							end else begin
								acc_q <= 32'd1;
								sq_q <= b;
								exp_q <= a;
								st_q <= S_PMUL;
							end
						end else begin
							rem_q <= 32'd0;
							quo_q <= b_mag;
							den_q <= a_mag;
							neg_q <= b[31] ^ a[31];
							cnt_q <= 6'd0;
							st_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						st_q <= S_IDLE;
						done <= 1'b1;
						res <= neg_q
							? (32'd0 - {quo_q[30:0], ~trial[32]})
							: {quo_q[30:0], ~trial[32]};
					end
				end
				S_PMUL: begin
					if (exp_q == 32'd0) begin
						st_q <= S_IDLE;
						done <= 1'b1;
						res <= acc_q;
					end else begin
						if (exp_q[0]) acc_q <= acc_q * sq_q;
						st_q <= S_PSQ;
					end
				end
				S_PSQ: begin
					sq_q <= sq_q * sq_q;
					exp_q <= {1'b0, exp_q[31:1]};
					st_q <= S_PMUL;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/pfe_back.sv]
// ----------------------------------------------------------------------------
// pfe_back
// Execution unit: operand stack in RAM, top of stack held in a register,
// arithmetic, error tracking and the result register.
// ----------------------------------------------------------------------------
module pfe_back #(
	parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pfe_pkg::cmd_t cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   value,
	output logic [1:0]    status
);

	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [4:0] {
		E_IDLE = 5'b00001,
		E_RD   = 5'b00010,
		E_OP   = 5'b00100,
		E_WAIT = 5'b01000,
		E_FIN  = 5'b10000
	} est_t;

	// entries below sp-1 live in RAM; the top is held in tos_q
	est_t          st_q;
	logic [PW-1:0] sp_q;
	logic [31:0]   tos_q;
	logic [1:0]    err_q;
	pfe_pkg::cmd_t c_q;
	logic [31:0]   prod_q;
	logic          we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	logic          dp_start;
	logic          dp_done;
	logic [31:0]   dp_res;
	logic          take;
	logic          is_op;
	logic [PW-1:0] sp_m1;
	logic [PW-1:0] sp_m2;

	assign sp_m1 = sp_q - PW'(1);
	assign sp_m2 = sp_q - PW'(2);
	assign take = cmd_valid && cmd_ready;
	assign cmd_ready = (st_q == E_IDLE) && !out_valid;
	assign is_op = (cmd.kind != pfe_pkg::K_NOP) && (cmd.kind != pfe_pkg::K_PUSH);
	// push spills the old top into RAM
	assign we = take && (cmd.kind == pfe_pkg::K_PUSH) && (sp_q < PW'(STACK_DEPTH))
		&& (sp_q != PW'(0));
	assign waddr = sp_m1[AW-1:0];
	assign raddr = sp_m2[AW-1:0];
	assign dp_start = (st_q == E_OP)
		&& ((c_q.kind == pfe_pkg::K_DIV && tos_q != 32'd0) || c_q.kind == pfe_pkg::K_POW);

	pfe_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (tos_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	pfe_divpow u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dp_start),
		.is_pow (c_q.kind == pfe_pkg::K_POW),
		.b      (rdata),
		.a      (tos_q),
		.done   (dp_done),
		.res    (dp_res)
	);

	always_ff @(posedge clk) begin
		if (st_q == E_OP) prod_q <= rdata * tos_q;
		if (take) c_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= E_IDLE;
			sp_q <= '0;
			tos_q <= 32'd0;
			err_q <= pfe_pkg::ST_OK;
			out_valid <= 1'b0;
			value <= 32'd0;
			status <= pfe_pkg::ST_OK;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (take) begin
						if (cmd.kind == pfe_pkg::K_PUSH) begin
							if (sp_q >= PW'(STACK_DEPTH)) begin
								if (err_q == pfe_pkg::ST_OK) err_q <= pfe_pkg::ST_OVER;
							end else begin
								tos_q <= {28'd0, cmd.digit};
								sp_q <= sp_q + PW'(1);
							end
							st_q <= cmd.last ? E_FIN : E_IDLE;
						end else if (is_op) begin
							if (sp_q < PW'(2)) begin
								if (err_q == pfe_pkg::ST_OK) err_q <= pfe_pkg::ST_UNDER;
								st_q <= cmd.last ? E_FIN : E_IDLE;
							end else begin
								st_q <= E_RD;
							end
						end else begin
							st_q <= cmd.last ? E_FIN : E_IDLE;
						end
					end
				end
				E_RD: st_q <= E_OP;
				E_OP: begin
					sp_q <= sp_m1;
					unique case (c_q.kind)
						pfe_pkg::K_ADD: begin
							tos_q <= rdata + tos_q;
							st_q <= c_q.last ? E_FIN : E_IDLE;
						end
						pfe_pkg::K_SUB: begin
							tos_q <= rdata - tos_q;
							st_q <= c_q.last ? E_FIN : E_IDLE;
						end
						pfe_pkg::K_MUL: st_q <= E_WAIT;
						pfe_pkg::K_DIV: begin
							if (tos_q == 32'd0) begin
								tos_q <= 32'd0;
								if (err_q == pfe_pkg::ST_OK) err_q <= pfe_pkg::ST_DIVZ;
								st_q <= c_q.last ? E_FIN : E_IDLE;
							end else begin
								st_q <= E_WAIT;
							end
						end
						default: st_q <= E_WAIT;
					endcase
				end
				E_WAIT: begin
					if (c_q.kind == pfe_pkg::K_MUL) begin
						tos_q <= prod_q;
						st_q <= c_q.last ? E_FIN : E_IDLE;
					end else if (dp_done) begin
						tos_q <= dp_res;
						st_q <= c_q.last ? E_FIN : E_IDLE;
					end
				end
				E_FIN: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						if (sp_q == PW'(0)) begin
							value <= 32'd0;
							status <= (err_q == pfe_pkg::ST_OK) ? pfe_pkg::ST_UNDER : err_q;
						end else begin
							value <= tos_q;
							status <= err_q;
						end
						sp_q <= '0;
						err_q <= pfe_pkg::ST_OK;
						st_q <= E_IDLE;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

endmodule

[rtl/postfix_expression_evaluator_core.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix evaluator with a 32-bit operand stack and sticky error status.
// ----------------------------------------------------------------------------
// Characters enter on the s_axis port; digits push, + - * / ^ combine the
// two top entries, anything else is ignored. After the word marked tlast one
// result (value, status) appears on m_axis. A two-word queue decouples the
// decoder from the execution unit. Digits and ignored characters finish in
// idle; + and - pass the read and operate states, * waits for the product,
// / computes one quotient bit per cycle (skipped on a zero divisor) and ^ a
// multiply and a square per exponent bit; the final word adds the result load.
module postfix_expression_evaluator_core #(
	parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] ch
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // [31:0] value, [33:32] status, zero fill
);

	logic          cmd_valid;
	logic          cmd_ready;
	pfe_pkg::cmd_t cmd;
	logic [31:0]   value;
	logic [1:0]    status;

	pfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.ch        (s_axis_tdata),
		.last      (s_axis_tlast),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	pfe_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.value     (value),
		.status    (status)
	);

	assign m_axis_tdata = {6'd0, status, value};

endmodule
